>>> hdl/utx_pkg.sv
package utx_pkg;

  // Bit timing
  localparam logic [15:0] MinTicks   = 16'd40;
  localparam logic [15:0] ResetTicks = 16'd104;

  // Frame positions: start bit is 0, data bits 1..8, stop bit 9
  localparam logic [3:0] FirstDataPos = 4'd1;
  localparam logic [3:0] LastDataPos  = 4'd8;
  localparam logic [3:0] StopPos      = 4'd9;

  // Config register index (paddr[2])
  localparam logic RegTicksPerBit = 1'b0;

  // Result field widths
  localparam int unsigned CountW   = 9;
  localparam int unsigned ResultW  = 12;
  localparam int unsigned MDataW   = 16;

  typedef struct packed {
    logic full;
    logic empty;
  } utx_fifo_stat_t;

endpackage

>>> hdl/utx_ram.sv
module utx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/utx_fifo.sv
module utx_fifo #(
  parameter int unsigned Depth = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [7:0]                   wdata_i,
  input  logic                         pop_i,
  output logic [7:0]                   rdata_o,
  output utx_pkg::utx_fifo_stat_t      stat_o,
  output logic [$clog2(Depth)-1:0]     count_next_o
);
  import utx_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [PtrW:0]   DepthW  = (PtrW+1)'(Depth);

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] count_now;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  // occupancy with wrap at Depth (need not be a power of two)
  function automatic logic [PtrW-1:0] occupancy(input logic [PtrW-1:0] w,
                                                input logic [PtrW-1:0] r);
    logic [PtrW:0] diff;
    diff = (w >= r) ? ({1'b0, w} - {1'b0, r}) : ({1'b0, w} + DepthW - {1'b0, r});
    occupancy = diff[PtrW-1:0];
  endfunction

  assign wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
  assign rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;

  assign count_now    = occupancy(wr_ptr_q, rd_ptr_q);
  assign count_next_o = occupancy(wr_ptr_d, rd_ptr_d);

  assign stat_o.full  = (count_now >= LastIdx);
  assign stat_o.empty = (count_now == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // head entry is read every cycle; the popped entry's data is valid in the cycle after a pop
  utx_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (wr_ptr_q),
    .wdata_i (wdata_i),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata_o)
  );

endmodule

>>> hdl/utx_ser.sv
module utx_ser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tick_i,
  input  logic                    push_i,
  input  logic [7:0]              byte_i,
  input  utx_pkg::utx_fifo_stat_t fifo_stat_i,
  input  logic [7:0]              fifo_rdata_i,
  input  logic [15:0]             bit_len_i,
  output logic                    pop_o,
  output logic                    line_next_o,
  output logic                    busy_next_o
);
  import utx_pkg::*;

  logic        sending_q, sending_d;
  logic [3:0]  bit_pos_q, bit_pos_d;
  logic [7:0]  frame_byte_q, frame_byte_d;
  logic [15:0] tick_cnt_q, tick_cnt_d;
  logic        line_q, line_d;
  logic        load_q, load_d;
  logic [15:0] tick_inc;
  logic [3:0]  pos_inc;
  logic [2:0]  bit_idx;

  assign tick_inc = tick_cnt_q + 16'd1;
  assign pos_inc  = bit_pos_q + 4'd1;
  assign bit_idx  = 3'(pos_inc - FirstDataPos);

  always_comb begin
    sending_d    = sending_q;
    bit_pos_d    = bit_pos_q;
    frame_byte_d = frame_byte_q;
    tick_cnt_d   = tick_cnt_q;
    line_d       = line_q;
    load_d       = 1'b0;
    pop_o        = 1'b0;

    // byte popped on the previous cycle: RAM data now valid
    if (load_q) begin
      frame_byte_d = fifo_rdata_i;
    end

    if (push_i && !sending_q) begin
      // idle: FIFO is empty, so the new byte goes straight out
      pop_o        = 1'b1;
      frame_byte_d = byte_i;
      bit_pos_d    = '0;
      sending_d    = 1'b1;
      tick_cnt_d   = '0;
      line_d       = 1'b0;
    end else if (tick_i && sending_q) begin
      if (tick_inc >= bit_len_i || tick_inc == '0) begin
        tick_cnt_d = '0;
        bit_pos_d  = pos_inc;
        if (pos_inc >= FirstDataPos && pos_inc <= LastDataPos) begin
          line_d = frame_byte_q[bit_idx];
        end else if (pos_inc == StopPos) begin
          line_d = 1'b1;
        end else begin
          // stop bit done: chain next byte or go idle
          line_d = 1'b1;
          if (!fifo_stat_i.empty) begin
            pop_o     = 1'b1;
            load_d    = 1'b1;
            bit_pos_d = '0;
            line_d    = 1'b0;
          end else begin
            sending_d = 1'b0;
          end
        end
      end else begin
        tick_cnt_d = tick_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q    <= 1'b0;
      bit_pos_q    <= '0;
      frame_byte_q <= '0;
      tick_cnt_q   <= '0;
      line_q       <= 1'b1;
      load_q       <= 1'b0;
    end else begin
      sending_q    <= sending_d;
      bit_pos_q    <= bit_pos_d;
      frame_byte_q <= frame_byte_d;
      tick_cnt_q   <= tick_cnt_d;
      line_q       <= line_d;
      load_q       <= load_d;
    end
  end

  assign line_next_o = line_d;
  assign busy_next_o = sending_d;

endmodule

>>> hdl/uart_tx_with_fifo_top.sv
// 8N1 serial transmitter model fed from a byte FIFO.
//
// Input stream: each beat is one timer tick (tuser = 0) or one byte to
// queue (tuser = 1, byte in tdata). A byte offered to a full FIFO is
// dropped; Depth-1 entries are usable. A byte queued while idle starts
// its frame at once (start bit low). Each bit lasts the programmed bit
// period in ticks, data LSB first, then a high stop bit; the next queued
// byte follows the stop bit directly.
// Output stream: one beat per input beat with the line level, busy flag,
// accepted flag and FIFO occupancy after that input.
// Config: APB, register 0 (addr 0x0) = bit period in ticks, writes below
// 40 are stored as 40.
// The result is in the output register in the cycle after the input
// beat. Throughput: one beat per cycle unless the receiver stalls; the
// state update and FIFO pointer step are combinational before it.
// Receiver stall: the result is held and s_axis_tready drops while the
// output register is full and m_axis_tready is low.
// Reset: line high, idle, FIFO empty, bit period = 104 ticks.
module uart_tx_with_fifo_top #(
  parameter int unsigned FifoDepth = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] action: 0 tick, 1 queue byte
  // result beats
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [0] tx_line, [1] busy_res,
                                        // [2] accepted, [11:3] bytes_waiting,
                                        // [15:12] zero
  // config
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import utx_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned ExtW = (PtrW > CountW) ? PtrW : CountW;

  logic                in_beat;
  logic                push;
  logic                tick;
  logic                pop;
  logic                line_next;
  logic                busy_next;
  logic [7:0]          fifo_rdata;
  logic [PtrW-1:0]     count_next;
  logic [ExtW-1:0]     count_ext;
  utx_fifo_stat_t      fifo_stat;

  logic [15:0]         tpb_q;
  logic [15:0]         wr_val;
  logic                cfg_wr;

  logic                out_valid_q, out_valid_d;
  logic [ResultW-1:0]  out_data_q;
  logic [ResultW-1:0]  result;

  // ---------------- config ----------------
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == RegTicksPerBit);
  assign wr_val   = (pwdata_i[15:0] < MinTicks) ? MinTicks : pwdata_i[15:0];
  assign prdata_o = (paddr_i[2] == RegTicksPerBit) ? {16'd0, tpb_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q <= ResetTicks;
    end else if (cfg_wr) begin
      tpb_q <= wr_val;
    end
  end

  // ---------------- input side ----------------
  // free output register, or one being drained this cycle
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = in_beat && s_axis_tuser_i && !fifo_stat.full;
  assign tick            = in_beat && !s_axis_tuser_i;

  utx_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .wdata_i      (s_axis_tdata_i),
    .pop_i        (pop),
    .rdata_o      (fifo_rdata),
    .stat_o       (fifo_stat),
    .count_next_o (count_next)
  );

  utx_ser u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .push_i       (push),
    .byte_i       (s_axis_tdata_i),
    .fifo_stat_i  (fifo_stat),
    .fifo_rdata_i (fifo_rdata),
    .bit_len_i    (tpb_q),
    .pop_o        (pop),
    .line_next_o  (line_next),
    .busy_next_o  (busy_next)
  );

  // occupancy masked to the 9-bit field
  assign count_ext = ExtW'(count_next);
  assign result    = {count_ext[CountW-1:0], push, busy_next, line_next};

  // ---------------- output register ----------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_beat) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(MDataW-ResultW)'(0), out_data_q};

endmodule
